[rtl/dtlv_pkg.sv]
// Shared types and constants for the DER TLV header parser.
package dtlv_pkg;

    // Default parameter values
    localparam int DEF_OFFSET_BITS       = 32;
    localparam int DEF_MAX_LENGTH_OCTETS = 8;

    // Octet field masks and limits
    localparam logic [7:0] TAG_NUM_MASK  = 8'h1F;
    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [6:0] COUNT_MASK    = 7'h7F;
    localparam logic [7:0] ZERO_OCTET    = 8'h00;
    localparam logic [7:0] MIN_LONG_LEN  = 8'h80;

    // Header parse phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_LONG_FIRST,
        PH_LONG_MORE
    } phase_t;

    // One input request
    typedef struct packed {
        logic        start_of_value;
        logic [7:0]  data_byte;
        logic [31:0] value_position;
        logic [31:0] buffer_length;
    } in_item_t;

    // One result request
    typedef struct packed {
        logic        header_ok;
        logic [7:0]  tag_octet;
        logic [31:0] content_offset;
        logic [31:0] content_length;
        logic [31:0] next_offset;
    } res_item_t;

endpackage

[rtl/dtlv_in_reg.sv]
// Input register stage: holds one accepted request until the decoder takes it.
module dtlv_in_reg
    import dtlv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;
    logic     accept;

    // Free slot, or the held request leaves this cycle
    assign in_ready = !valid_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[rtl/dtlv_decode.sv]
// Header decoder: parse state and the single-pass decode of one byte.
module dtlv_decode
    import dtlv_pkg::*;
#(
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
    parameter int MAX_LENGTH_OCTETS = DEF_MAX_LENGTH_OCTETS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  in_item_t  item,
    output logic      res_valid,
    output res_item_t res
);

    localparam int OW   = OFFSET_BITS;
    localparam int AW   = 8 * MAX_LENGTH_OCTETS;
    localparam int CW   = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int CMPW = (AW > OW) ? AW : OW;

    phase_t          phase_reg, phase_next;
    logic [7:0]      tag_reg, tag_next;
    logic [OW-1:0]   cur_reg, cur_next;
    logic [OW-1:0]   lim_reg, lim_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic            lzs_reg, lzs_next;

    // Bound check and result fields for a finished header
    function automatic res_item_t finish(input logic [OW-1:0] p, input logic [AW-1:0] n,
                                         input logic [OW-1:0] lim, input logic [7:0] tag);
        res_item_t r;
        logic [OW-1:0] room;
        r    = '0;
        room = lim - p;
        if (!(p > lim) && !(CMPW'(n) > CMPW'(room))) begin
            r.header_ok      = 1'b1;
            r.tag_octet      = tag;
            r.content_offset = 32'(p);
            r.content_length = 32'(n);
            r.next_offset    = 32'(CMPW'(p) + CMPW'(n));
        end
        return r;
    endfunction

    // Decode one byte against the current phase
    always_comb begin
        logic [63:0]   pos_wide, lim_wide;
        logic [OW-1:0] pos, lim_in, p, room, cur_inc;
        logic [7:0]    b;
        logic [6:0]    count;
        logic [AW-1:0] acc_new;
        logic [CW-1:0] rem_new;
        logic          lzs_new;

        phase_next = phase_reg;
        tag_next   = tag_reg;
        cur_next   = cur_reg;
        lim_next   = lim_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        lzs_next   = lzs_reg;
        res_valid  = 1'b0;
        res        = '0;

        b        = item.data_byte;
        pos_wide = {32'b0, item.value_position};
        lim_wide = {32'b0, item.buffer_length};
        pos      = pos_wide[OW-1:0];
        lim_in   = lim_wide[OW-1:0];
        p        = cur_reg + OW'(1);
        room     = lim_reg - p;
        count    = b[6:0] & COUNT_MASK;
        cur_inc  = cur_reg + OW'(1);
        acc_new  = AW'({acc_reg, b});
        rem_new  = rem_reg - CW'(1);
        lzs_new  = (phase_reg == PH_LONG_FIRST) ? (b == ZERO_OCTET) : lzs_reg;

        if (en) begin
            if (item.start_of_value) begin
                // Identifier octet: restart, refuse on a multi-octet tag number or when no room for a length octet
                lim_next = lim_in;
                tag_next = b;
                if (pos >= lim_in || (b & TAG_NUM_MASK) == TAG_NUM_MASK ||
                    pos + OW'(1) >= lim_in) begin
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    cur_next   = pos + OW'(1);
                    phase_next = PH_LEN;
                end
            end else begin
                case (phase_reg)
                    PH_LEN: begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if ((b & LONG_FORM_BIT) == ZERO_OCTET) begin
                            res = finish(p, AW'(b), lim_reg, tag_reg);
                        end else if (count == 7'd0 ||
                                     32'(count) > 32'(MAX_LENGTH_OCTETS)) begin
                            res = '0;
                        end else if (p > lim_reg || OW'(count) > room) begin
                            res = '0;
                        end else begin
                            // Start of a long length form
                            res_valid  = 1'b0;
                            cur_next   = p;
                            rem_next   = CW'(count);
                            acc_next   = '0;
                            lzs_next   = 1'b0;
                            phase_next = PH_LONG_FIRST;
                        end
                    end
                    PH_LONG_FIRST, PH_LONG_MORE: begin
                        // Shift in one length octet
                        acc_next   = acc_new;
                        lzs_next   = lzs_new;
                        cur_next   = cur_inc;
                        rem_next   = rem_new;
                        phase_next = PH_LONG_MORE;
                        if (rem_new == '0) begin
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                            if (acc_new < AW'(MIN_LONG_LEN) || lzs_new) begin
                                res = '0;
                            end else begin
                                res = finish(cur_inc, acc_new, lim_reg, tag_reg);
                            end
                        end
                    end
                    default: begin
                        // Stray bytes while idle are dropped
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        cur_reg <= cur_next;
        lim_reg <= lim_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        lzs_reg <= lzs_next;
    end

endmodule

[rtl/dtlv_out_reg.sv]
// Result register: holds one decoded header until the sink takes it.
module dtlv_out_reg
    import dtlv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  res_item_t res_in,
    output logic      out_valid,
    input  logic      out_ready,
    output res_item_t res_out
);

    logic      valid_reg, valid_next;
    res_item_t res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

[rtl/der_tlv_header_parser.sv]
// Top level of the DER TLV header parser.
// Decodes one DER identifier-and-length header from a byte stream, one byte per
// cycle, with a byte marked by s_axis_tuser starting a new value. Each accepted
// byte passes through an input register and one decode stage whose parse state
// updates with each decoded byte, so a new byte is taken each cycle unless the
// output stalls; the result of the byte that ends or refuses the header is
// loaded from the decode stage into the output register, where the sink can
// take it. The rate is one byte per cycle, set by the single decode stage
// and its parse state registers; it drops only while a finished result
// waits unread. Long length forms of 1 to MAX_LENGTH_OCTETS octets are
// supported; on refusal header_ok is 0 and all other result fields are 0.
module der_tlv_header_parser
    import dtlv_pkg::*;
#(
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
    parameter int MAX_LENGTH_OCTETS = DEF_MAX_LENGTH_OCTETS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] data_byte, [39:8] value_position, [71:40] buffer_length
    input  logic [71:0]  s_axis_tdata,
    // [0] start_of_value
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] tag_octet, [39:8] content_offset, [71:40] content_length,
    // [103:72] next_offset
    output logic [103:0] m_axis_tdata,
    // [0] header_ok
    output logic [0:0]   m_axis_tuser
);

    in_item_t  s_item, held_item;
    res_item_t dec_res, out_res;
    logic      held_valid, advance, dec_valid;

    // Unpack the input request
    assign s_item.start_of_value = s_axis_tuser[0];
    assign s_item.data_byte      = s_axis_tdata[7:0];
    assign s_item.value_position = s_axis_tdata[39:8];
    assign s_item.buffer_length  = s_axis_tdata[71:40];

    // Decode advances when the result register can take whatever comes out
    assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

    dtlv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (s_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    dtlv_decode #(
        .OFFSET_BITS       (OFFSET_BITS),
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .item      (held_item),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    dtlv_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && dec_valid),
        .res_in    (dec_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_out   (out_res)
    );

    // Pack the result request
    assign m_axis_tuser[0]       = out_res.header_ok;
    assign m_axis_tdata[7:0]     = out_res.tag_octet;
    assign m_axis_tdata[39:8]    = out_res.content_offset;
    assign m_axis_tdata[71:40]   = out_res.content_length;
    assign m_axis_tdata[103:72]  = out_res.next_offset;

`ifndef SYNTHESIS
    // A refusal carries all-zero fields
    a_refuse_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 104'd0)
        else $error("refused header with nonzero fields");

    // Next offset is content offset plus content length
    a_next_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[103:72] == m_axis_tdata[39:8] + m_axis_tdata[71:40])
        else $error("next offset mismatch");

    // Input side stalls only behind an unread result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the DER TLV header parser stream block.
`timescale 1ns / 100ps

module tb_top;
    import dtlv_pkg::*;

    localparam int MAX_LEN_OCTS = DEF_MAX_LENGTH_OCTETS;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata  = '0;
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // pacing, percent of cycles spent idle on each side
    int tx_idle_pct = 36;
    int rx_idle_pct = 55;

    // decoder shadow state
    phase_t      hdr_phase  = PH_IDLE;
    logic [7:0]  hdr_tag    = '0;
    logic [63:0] hdr_offset = '0;
    logic [63:0] buf_limit  = '0;
    logic [3:0]  octs_left  = '0;
    logic [63:0] len_acc    = '0;
    bit          lead_zero  = 1'b0;

    res_item_t   pending_headers[$];

    int mismatches    = 0;
    int results_seen  = 0;
    int ok_results    = 0;
    int header_starts = 0;
    int live_bytes    = 0;
    int quiet_cycles  = 0;

    der_tlv_header_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Header decode prediction
    // ------------------------------------------------------------------
    function automatic void refuse_header();
        res_item_t r;
        r = '0;
        pending_headers.push_back(r);
        hdr_phase = PH_IDLE;
    endfunction

    // p = first content byte, n = content length
    function automatic void finish_header(input logic [63:0] p, input logic [63:0] n);
        res_item_t   r;
        logic [63:0] nxt;
        if (p > buf_limit || n > buf_limit - p) begin
            refuse_header();
            return;
        end
        nxt              = p + n;
        r.header_ok      = 1'b1;
        r.tag_octet      = hdr_tag;
        r.content_offset = p[31:0];
        r.content_length = n[31:0];
        r.next_offset    = nxt[31:0];
        pending_headers.push_back(r);
        hdr_phase = PH_IDLE;
    endfunction

    function automatic void predict_byte(input in_item_t it);
        logic [63:0] pos;
        logic [63:0] p;
        logic [7:0]  b;
        int unsigned cnt;
        b = it.data_byte;
        // identifier octet restarts everything
        if (it.start_of_value) begin
            pos       = {32'd0, it.value_position};
            buf_limit = {32'd0, it.buffer_length};
            hdr_tag   = b;
            if (pos >= buf_limit || (b & TAG_NUM_MASK) == TAG_NUM_MASK
                    || pos + 64'd1 >= buf_limit) begin
                refuse_header();
            end else begin
                hdr_offset = pos + 64'd1;
                hdr_phase  = PH_LEN;
            end
            return;
        end
        case (hdr_phase)
            PH_LEN: begin
                p = hdr_offset + 64'd1;
                if ((b & LONG_FORM_BIT) == 8'd0) begin
                    finish_header(p, {56'd0, b});
                end else begin
                    cnt = 32'(b & COUNT_MASK);
                    if (cnt == 0 || cnt > MAX_LEN_OCTS) begin
                        refuse_header();
                    end else if (p > buf_limit || 64'(cnt) > buf_limit - p) begin
                        refuse_header();
                    end else begin
                        hdr_offset = p;
                        octs_left  = cnt[3:0];
                        len_acc    = '0;
                        lead_zero  = 1'b0;
                        hdr_phase  = PH_LONG_FIRST;
                    end
                end
            end
            PH_LONG_FIRST, PH_LONG_MORE: begin
                if (hdr_phase == PH_LONG_FIRST)
                    lead_zero = (b == ZERO_OCTET);
                len_acc    = (len_acc << 8) | {56'd0, b};
                hdr_offset = hdr_offset + 64'd1;
                octs_left  = octs_left - 4'd1;
                hdr_phase  = PH_LONG_MORE;
                if (octs_left == 4'd0) begin
                    if (len_acc < {56'd0, MIN_LONG_LEN} || lead_zero)
                        refuse_header();
                    else
                        finish_header(hdr_offset, len_acc);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: called and returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input bit sov, input logic [7:0] b,
                             input logic [31:0] pos, input logic [31:0] blen);
        in_item_t it;
        it.start_of_value = sov;
        it.data_byte      = b;
        it.value_position = pos;
        it.buffer_length  = blen;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blen, pos, b};
        s_axis_tuser  <= sov;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (sov) header_starts++;
        if (sov || hdr_phase != PH_IDLE) live_bytes++;
        predict_byte(it);
        @(negedge aclk);
    endtask

    // hold off the sender until every predicted header has come out
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_headers.size() != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Random header: mostly well formed, some broken or cut short
    // ------------------------------------------------------------------
    task automatic send_random_header();
        logic [63:0] pos;
        logic [63:0] lim;
        logic [63:0] n;
        logic [7:0]  tag;
        logic [7:0]  hdr [0:8];
        int unsigned kind, cnt, nbytes, nsend, i;
        bit          wide;
        kind = $urandom_range(0, 99);
        wide = ($urandom_range(0, 4) == 0);
        pos  = wide ? {32'd0, $urandom} : 64'($urandom_range(0, 300));
        lim  = {32'd0, $urandom};
        tag  = 8'($urandom_range(0, 255));
        if ((tag & TAG_NUM_MASK) == TAG_NUM_MASK && $urandom_range(0, 9) != 0)
            tag = tag ^ 8'h01;
        cnt = 0;

        if (kind < 40) begin
            // short form
            n      = 64'($urandom_range(0, 127));
            hdr[0] = n[7:0];
            nbytes = 1;
            if (!wide)
                lim = ($urandom_range(0, 99) < 85) ? pos + 64'd2 + n + $urandom_range(0, 8)
                                                   : pos + $urandom_range(0, 140);
        end else if (kind < 85) begin
            // minimal long form
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_LEN_OCTS)
                                              : $urandom_range(1, 4);
            n   = {$urandom, $urandom} >> (64 - 8 * cnt);
            if (cnt == 1)
                n[7] = 1'b1;
            else if (n[8*cnt-1 -: 8] == 8'd0)
                n[8*cnt-1 -: 8] = 8'h01;
            hdr[0] = LONG_FORM_BIT | 8'(cnt);
            for (i = 0; i < cnt; i++)
                hdr[i+1] = n[8*(cnt-1-i) +: 8];
            nbytes = cnt + 1;
            if (!wide)
                lim = ($urandom_range(0, 99) < 80)
                      ? pos + 64'd2 + cnt + n + $urandom_range(0, 20)
                      : pos + $urandom_range(0, 12);
        end else begin
            // malformed length field
            case ($urandom_range(0, 3))
                0: begin
                    hdr[0] = LONG_FORM_BIT;
                    nbytes = 1;
                end
                1: begin
                    hdr[0] = LONG_FORM_BIT | 8'($urandom_range(MAX_LEN_OCTS + 1, 127));
                    nbytes = 1;
                end
                2: begin
                    cnt    = $urandom_range(2, 4);
                    hdr[0] = LONG_FORM_BIT | 8'(cnt);
                    hdr[1] = ZERO_OCTET;
                    for (i = 2; i <= cnt; i++)
                        hdr[i] = 8'($urandom_range(0, 255));
                    nbytes = cnt + 1;
                end
                default: begin
                    hdr[0] = LONG_FORM_BIT | 8'd1;
                    hdr[1] = 8'($urandom_range(0, 127));
                    nbytes = 2;
                end
            endcase
            if (!wide)
                lim = pos + $urandom_range(0, 400);
        end
        if (lim > 64'hFFFF_FFFF)
            lim = 64'hFFFF_FFFF;

        // stray bytes ahead of the header
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 2))
                send_item(1'b0, 8'($urandom_range(0, 255)), $urandom, $urandom);

        // occasionally abandon the header part way
        nsend = ($urandom_range(0, 19) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
        send_item(1'b1, tag, pos[31:0], lim[31:0]);
        for (i = 0; i < nsend; i++)
            send_item(1'b0, hdr[i], $urandom, $urandom);

        // a few content bytes, ignored by the parser
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_item(1'b0, 8'($urandom_range(0, 255)), $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------
    task automatic test_refusals();
        // identifier outside an empty buffer
        send_item(1'b1, 8'h30, 32'd0, 32'd0);
        // identifier on the last byte, no room for the length octet
        send_item(1'b1, 8'h30, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // multi-octet tag number
        send_item(1'b1, 8'hFF, 32'd0, 32'd100);
        // indefinite length
        send_item(1'b1, 8'h30, 32'd0, 32'd100);
        send_item(1'b0, LONG_FORM_BIT, $urandom, $urandom);
        // more length octets than supported
        send_item(1'b1, 8'h04, 32'd0, 32'd100);
        send_item(1'b0, 8'hFF, $urandom, $urandom);
        // length octets run past buffer end
        send_item(1'b1, 8'h04, 32'd0, 32'd4);
        send_item(1'b0, 8'h83, $urandom, $urandom);
        // long form carrying a value that fits the short form
        send_item(1'b1, 8'h02, 32'd0, 32'd100);
        send_item(1'b0, 8'h81, $urandom, $urandom);
        send_item(1'b0, 8'h7F, $urandom, $urandom);
        // leading zero length octet
        send_item(1'b1, 8'h02, 32'd0, 32'd1000);
        send_item(1'b0, 8'h82, $urandom, $urandom);
        send_item(1'b0, ZERO_OCTET, $urandom, $urandom);
        send_item(1'b0, 8'h80, $urandom, $urandom);
    endtask

    task automatic test_valid_forms();
        // zero-length content right at the buffer end
        send_item(1'b1, 8'h00, 32'd0, 32'd2);
        send_item(1'b0, 8'h00, $urandom, $urandom);
        // short form ending exactly on the largest offset
        send_item(1'b1, 8'h05, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_item(1'b0, 8'h0D, $urandom, $urandom);
        // shortest legal long form
        send_item(1'b1, 8'hE3, 32'd0, 32'd200);
        send_item(1'b0, 8'h81, $urandom, $urandom);
        send_item(1'b0, 8'h80, $urandom, $urandom);
    endtask

    task automatic test_idle_and_restart();
        // stray byte with nothing under way
        send_item(1'b0, 8'hA5, $urandom, $urandom);
        // restart in the middle of a long form
        send_item(1'b1, 8'h30, 32'd5, 32'd100);
        send_item(1'b0, 8'h82, $urandom, $urandom);
        send_item(1'b1, 8'h31, 32'd0, 32'd50);
        send_item(1'b0, 8'h10, $urandom, $urandom);
    endtask

    task automatic test_drain_pause();
        send_item(1'b1, 8'h04, 32'd10, 32'd40);
        send_item(1'b0, 8'h05, $urandom, $urandom);
        wait_for_drain();
        send_item(1'b1, 8'h04, 32'd17, 32'd40);
        send_item(1'b0, 8'h05, $urandom, $urandom);
    endtask

    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int count);
        int goal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal        = live_bytes + count;
        while (live_bytes < goal) begin
            send_random_header();
            if ($urandom_range(0, 49) == 0)
                wait_for_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: backpressure and checking
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h (result %0d)",
                         name, want, got, results_seen);
        end
    endtask

    always @(posedge aclk) begin : result_check
        res_item_t got;
        res_item_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.header_ok      = m_axis_tuser[0];
            got.tag_octet      = m_axis_tdata[7:0];
            got.content_offset = m_axis_tdata[39:8];
            got.content_length = m_axis_tdata[71:40];
            got.next_offset    = m_axis_tdata[103:72];
            results_seen++;
            if (pending_headers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%b tag=%h off=%h len=%h next=%h",
                             got.header_ok, got.tag_octet, got.content_offset,
                             got.content_length, got.next_offset);
            end else begin
                want = pending_headers.pop_front();
                if (want.header_ok) ok_results++;
                check_field("header_ok", 32'(want.header_ok), 32'(got.header_ok));
                check_field("tag_octet", 32'(want.tag_octet), 32'(got.tag_octet));
                check_field("content_offset", want.content_offset, got.content_offset);
                check_field("content_length", want.content_length, got.content_length);
                check_field("next_offset", want.next_offset, got.next_offset);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("stalled for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_refusals();
        test_valid_forms();
        test_idle_and_restart();
        test_drain_pause();
        test_random_stream(36, 55, 600);
        test_random_stream(55, 36, 600);
        test_random_stream(0, 0, 600);

        s_axis_tvalid <= 1'b0;
        while (pending_headers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_headers.size() != 0) begin
            mismatches += pending_headers.size();
            $display("%0d expected results never arrived", pending_headers.size());
        end
        $display("covered %0d headers over %0d live bytes in three pacing modes",
                 header_starts, live_bytes);
        $display("checked %0d results (%0d decoded, %0d refused), %0d mismatches",
                 results_seen, ok_results, results_seen - ok_results, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
